// ----- hdl/otsu_frame_threshold_defines.svh -----
// Assertion macros for the Otsu threshold RTL, used by otsu_ft_back.
// Needs a clk and an active-low rst_n in the scope where a macro is used.
`ifndef OTSU_FRAME_THRESHOLD_DEFINES_SVH
`define OTSU_FRAME_THRESHOLD_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define OTSU_FT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define OTSU_FT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/otsu_ft_pkg.sv -----
// Shared constants and types for the Otsu frame threshold block.
// No dependencies; used by every module of the block.
`default_nettype none

package otsu_ft_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int NUM_BINS    = 256;
    localparam int PIX_W       = 8;
    // Pixel count and grey sum of one frame.
    localparam int N_W         = COUNT_WIDTH + 8;
    localparam int S_W         = COUNT_WIDTH + 16;
    // |s0*N - S*w0| and the operand widths of the shared multiplier.
    localparam int DIFF_W      = 2 * COUNT_WIDTH + 24;
    localparam int MA_W        = 4 * COUNT_WIDTH + 48;
    localparam int MB_W        = DIFF_W;
    localparam int MP_W        = MA_W + MB_W;
    localparam int MCNT_W      = $clog2(MB_W + 1);
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // One queued request: a pixel and its end-of-frame mark.
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last;
    } q_item_t;

    // Head of the request queue as seen by the back end.
    typedef struct packed {
        logic    valid;
        q_item_t item;
    } q_head_t;

    // Status of the serial multiplier.
    typedef struct packed {
        logic busy;
        logic done;
    } mul_stat_t;

    // Products computed for each candidate threshold (MOP_L and MOP_R only after the first).
    typedef enum logic [2:0] {
        MOP_A   = 3'd0,
        MOP_B   = 3'd1,
        MOP_NUM = 3'd2,
        MOP_DEN = 3'd3,
        MOP_L   = 3'd4,
        MOP_R   = 3'd5
    } mop_t;

endpackage

`default_nettype wire

// ----- hdl/otsu_ft_front.sv -----
// Front end: takes pixel requests from the input stream into a short queue.
// Depends on otsu_ft_pkg.
`default_nettype none

module otsu_ft_front (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       s_tvalid,
    output logic                      s_tready,
    input  wire  [7:0]                s_tdata,   // [7:0] pixel
    input  wire                       s_tlast,
    output otsu_ft_pkg::q_head_t      head,
    input  wire                       pop
);
    import otsu_ft_pkg::*;

    q_item_t             q_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;
    logic                push;

    assign s_tready = (count_reg != (QPTR_W + 1)'(QDEPTH));
    assign push     = s_tvalid && s_tready;

    assign head.valid = (count_reg != '0);
    assign head.item  = q_reg[rd_ptr_reg];

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= '{pixel: s_tdata[PIX_W-1:0], last: s_tlast};
        end
    end

    // Queue pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/otsu_ft_mul.sv -----
// Shift-and-add multiplier, one bit of the second operand per cycle.
// Depends on otsu_ft_pkg.
`default_nettype none

module otsu_ft_mul (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              start,
    input  wire  [otsu_ft_pkg::MA_W-1:0]     a,
    input  wire  [otsu_ft_pkg::MB_W-1:0]     b,
    output logic [otsu_ft_pkg::MP_W-1:0]     prod,
    output otsu_ft_pkg::mul_stat_t           stat
);
    import otsu_ft_pkg::*;

    logic [MP_W-1:0]   acc_reg;
    logic [MP_W-1:0]   ash_reg;
    logic [MB_W-1:0]   b_reg;
    logic [MCNT_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    assign prod      = acc_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    // Datapath: add the shifted multiplicand where the multiplier bit is set.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            ash_reg <= MP_W'(a);
            b_reg   <= b;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
            begin
                acc_reg <= acc_reg + ash_reg;
            end
            ash_reg <= ash_reg << 1;
            b_reg   <= b_reg >> 1;
        end
    end

    // Control: count the multiplier bits, pulse done after the last one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= MCNT_W'(MB_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == MCNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/otsu_ft_back.sv -----
// Back end: histogram memory, end-of-frame scan and threshold sweep.
// Depends on otsu_ft_pkg, otsu_ft_mul and the assertion macro header.
`default_nettype none
`include "otsu_frame_threshold_defines.svh"

module otsu_ft_back (
    input  wire                   clk,
    input  wire                   rst_n,
    input  otsu_ft_pkg::q_head_t  head,
    output logic                  pop,
    output logic                  m_tvalid,
    input  wire                   m_tready,
    output logic [7:0]            m_tdata    // [7:0] threshold
);
    import otsu_ft_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_UPD    = 10'b00_0000_0010,
        S_SC_RD  = 10'b00_0000_0100,
        S_SC_AC  = 10'b00_0000_1000,
        S_DEC    = 10'b00_0001_0000,
        S_SW_RD  = 10'b00_0010_0000,
        S_SW_AC  = 10'b00_0100_0000,
        S_MUL_GO = 10'b00_1000_0000,
        S_MUL_WT = 10'b01_0000_0000,
        S_OUT    = 10'b10_0000_0000
    } state_t;

    state_t                 state_reg;
    logic [COUNT_WIDTH-1:0] mem [NUM_BINS];
    logic [NUM_BINS-1:0]    valid_reg;
    logic [COUNT_WIDTH-1:0] rdata_reg;
    logic [PIX_W-1:0]       raddr_reg;
    logic [PIX_W-1:0]       raddr;
    logic [COUNT_WIDTH-1:0] bin;
    logic [PIX_W-1:0]       pix_reg;
    logic                   last_reg;
    logic [PIX_W-1:0]       idx_reg;
    logic                   found_reg;
    logic [PIX_W-1:0]       lo_reg;
    logic [PIX_W-1:0]       hi_reg;
    logic [N_W-1:0]         n_reg;
    logic [S_W-1:0]         s_reg;
    logic [N_W-1:0]         w0_reg;
    logic [S_W-1:0]         s0_reg;
    logic [DIFF_W-1:0]      a_reg;
    logic [DIFF_W-1:0]      b_reg;
    logic [DIFF_W-1:0]      diff;
    logic [MA_W-1:0]        num_reg;
    logic [MB_W-1:0]        den_reg;
    logic [MA_W-1:0]        bnum_reg;
    logic [MB_W-1:0]        bden_reg;
    logic [MP_W-1:0]        lhs_reg;
    logic                   have_reg;
    mop_t                   op_reg;
    logic [PIX_W-1:0]       thr_reg;
    logic [PIX_W-1:0]       out_reg;
    logic                   outv_reg;
    logic                   out_load;
    logic                   mul_start;
    logic [MA_W-1:0]        mul_a;
    logic [MB_W-1:0]        mul_b;
    logic [MP_W-1:0]        mul_p;
    mul_stat_t              mstat;

    otsu_ft_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .prod  (mul_p),
        .stat  (mstat)
    );

    assign m_tvalid  = outv_reg;
    assign m_tdata   = out_reg;
    assign out_load  = (state_reg == S_OUT) && (!outv_reg || m_tready);
    assign pop       = (state_reg == S_IDLE) && head.valid;
    assign mul_start = (state_reg == S_MUL_GO);
    assign bin       = valid_reg[raddr_reg] ? rdata_reg : '0;
    assign diff      = (a_reg >= b_reg) ? (a_reg - b_reg) : (b_reg - a_reg);

    // Memory read address.
    always_comb
    begin
        if (state_reg == S_IDLE)
        begin
            raddr = head.item.pixel;
        end
        else
        begin
            raddr = idx_reg;
        end
    end

    // Multiplier operands for the current product.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (op_reg)
            MOP_A:
            begin
                mul_a = MA_W'(s0_reg);
                mul_b = MB_W'(n_reg);
            end
            MOP_B:
            begin
                mul_a = MA_W'(s_reg);
                mul_b = MB_W'(w0_reg);
            end
            MOP_NUM:
            begin
                mul_a = MA_W'(diff);
                mul_b = diff;
            end
            MOP_DEN:
            begin
                mul_a = MA_W'(w0_reg);
                mul_b = MB_W'(n_reg - w0_reg);
            end
            MOP_L:
            begin
                mul_a = num_reg;
                mul_b = bden_reg;
            end
            MOP_R:
            begin
                mul_a = bnum_reg;
                mul_b = den_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Histogram memory with registered read.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
        raddr_reg <= raddr;
        if (state_reg == S_UPD)
        begin
            mem[pix_reg] <= (bin == COUNT_MAX) ? bin : bin + 1'b1;
        end
    end

    // Datapath registers of the scan and the sweep.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                pix_reg  <= head.item.pixel;
                last_reg <= head.item.last;
            end
            S_UPD:
            begin
                idx_reg <= '0;
                n_reg   <= '0;
                s_reg   <= '0;
            end
            S_SC_AC:
            begin
                if (bin != '0)
                begin
                    if (!found_reg)
                    begin
                        lo_reg <= idx_reg;
                    end
                    hi_reg <= idx_reg;
                end
                n_reg   <= n_reg + N_W'(bin);
                s_reg   <= s_reg + S_W'(S_W'(bin) * S_W'(idx_reg));
                idx_reg <= idx_reg + 1'b1;
            end
            S_DEC:
            begin
                idx_reg <= lo_reg;
                w0_reg  <= '0;
                s0_reg  <= '0;
                thr_reg <= lo_reg;
            end
            S_SW_AC:
            begin
                w0_reg <= w0_reg + N_W'(bin);
                s0_reg <= s0_reg + S_W'(S_W'(bin) * S_W'(idx_reg));
                op_reg <= MOP_A;
            end
            S_MUL_WT:
            begin
                if (mstat.done)
                begin
                    case (op_reg)
                        MOP_A:
                        begin
                            a_reg  <= mul_p[DIFF_W-1:0];
                            op_reg <= MOP_B;
                        end
                        MOP_B:
                        begin
                            b_reg  <= mul_p[DIFF_W-1:0];
                            op_reg <= MOP_NUM;
                        end
                        MOP_NUM:
                        begin
                            num_reg <= mul_p[MA_W-1:0];
                            op_reg  <= MOP_DEN;
                        end
                        MOP_DEN:
                        begin
                            den_reg <= mul_p[MB_W-1:0];
                            op_reg  <= MOP_L;
                            if (!have_reg)
                            begin
                                thr_reg  <= idx_reg;
                                bnum_reg <= num_reg;
                                bden_reg <= mul_p[MB_W-1:0];
                            end
                        end
                        MOP_L:
                        begin
                            lhs_reg <= mul_p;
                            op_reg  <= MOP_R;
                        end
                        MOP_R:
                        begin
                            if (lhs_reg > mul_p)
                            begin
                                thr_reg  <= idx_reg;
                                bnum_reg <= num_reg;
                                bden_reg <= den_reg;
                            end
                        end
                        default:
                        begin
                            op_reg <= MOP_A;
                        end
                    endcase
                    // Step to the next candidate once this one is settled.
                    if ((op_reg == MOP_R) || ((op_reg == MOP_DEN) && !have_reg))
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    out_reg <= thr_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control state, valid bits and the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            found_reg <= 1'b0;
            have_reg  <= 1'b0;
            outv_reg  <= 1'b0;
        end
        else
        begin
            // A result leaves the output register when it is taken.
            if (m_tready)
            begin
                outv_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (head.valid)
                    begin
                        state_reg <= S_UPD;
                    end
                end
                S_UPD:
                begin
                    valid_reg[pix_reg] <= 1'b1;
                    found_reg          <= 1'b0;
                    state_reg          <= last_reg ? S_SC_RD : S_IDLE;
                end
                S_SC_RD:
                begin
                    state_reg <= S_SC_AC;
                end
                S_SC_AC:
                begin
                    if (bin != '0)
                    begin
                        found_reg <= 1'b1;
                    end
                    state_reg <= (idx_reg == PIX_W'(NUM_BINS - 1)) ? S_DEC : S_SC_RD;
                end
                S_DEC:
                begin
                    have_reg <= 1'b0;
                    if ((hi_reg == lo_reg) ||
                        ({1'b0, hi_reg} == ({1'b0, lo_reg} + 9'd1)))
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_SW_RD;
                    end
                end
                S_SW_RD:
                begin
                    state_reg <= S_SW_AC;
                end
                S_SW_AC:
                begin
                    state_reg <= S_MUL_GO;
                end
                S_MUL_GO:
                begin
                    state_reg <= S_MUL_WT;
                end
                S_MUL_WT:
                begin
                    if (mstat.done)
                    begin
                        if ((op_reg == MOP_R) || ((op_reg == MOP_DEN) && !have_reg))
                        begin
                            have_reg <= 1'b1;
                            if ({1'b0, idx_reg} + 9'd1 == {1'b0, hi_reg})
                            begin
                                state_reg <= S_OUT;
                            end
                            else
                            begin
                                state_reg <= S_SW_RD;
                            end
                        end
                        else
                        begin
                            state_reg <= S_MUL_GO;
                        end
                    end
                end
                S_OUT:
                begin
                    // Hand the threshold over once the output register is free.
                    if (out_load)
                    begin
                        outv_reg  <= 1'b1;
                        valid_reg <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `OTSU_FT_ASSERT_IMP(a_mul_idle, mul_start, !mstat.busy,
        "multiplier started while busy")
    `OTSU_FT_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
        "result changed while waiting")
    `OTSU_FT_ASSERT_IMP(a_sweep_range, state_reg == S_SW_RD,
        (idx_reg < hi_reg) && (lo_reg <= idx_reg), "sweep index out of range")
    `OTSU_FT_ASSERT_NXT(a_clear, out_load, valid_reg == '0,
        "histogram not cleared after the frame")

endmodule

`default_nettype wire

// ----- hdl/otsu_frame_threshold.sv -----
// Otsu threshold of 8-bit grey frames, one result on each pixel marked last.
// Each pixel is a histogram read-modify-write, finished before the next one is
// popped from the queue; none is popped during the end-of-frame bin scan and
// threshold sweep. The sweep, skipped when the lowest and highest used levels
// are equal or adjacent, computes its products on the serial multiplier.
// Reset (async, active low) clears the queue, state and histogram valid bits.
`default_nettype none

module otsu_frame_threshold (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire  [7:0] s_tdata,   // [7:0] pixel
    input  wire        s_tlast,
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [7:0] m_tdata    // [7:0] threshold
);
    import otsu_ft_pkg::*;

    q_head_t head;
    logic    pop;

    otsu_ft_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .head     (head),
        .pop      (pop)
    );

    otsu_ft_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

// ----- tb/otsu_frame_threshold_test.sv -----
// Self-checking testbench for otsu_frame_threshold: streams grey frames,
// predicts each frame's threshold with its own histogram model, or takes it from
// the directed row, and checks it. Depends on otsu_ft_pkg and otsu_frame_threshold.
`timescale 1ns / 1ps

module otsu_frame_threshold_test;
    import otsu_ft_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;

    otsu_frame_threshold dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [7:0] pixel
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // [7:0] threshold
    );

    // One directed row: a pixel repeated rep times, last on the final copy if last is set.
    // want_thr < 0 means the threshold comes from the predictor.
    typedef struct {
        int pixel;
        int rep;
        bit last;
        int want_thr;
    } pixel_row_t;

    int unsigned        hist_bins [NUM_BINS];
    logic [7:0]         thr_queue [$];
    int                 mismatches;
    int                 pixels_sent;
    int                 frames_sent;
    int                 thresholds_seen;
    bit                 calm;
    bit                 hold_req;
    int                 hold_left;

    // Clock with a 2 ns period.
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Threshold sweep over the current histogram, exact integer compare.
    function automatic logic [7:0] otsu_level();
        int          lo;
        int          hi;
        int          t;
        logic [255:0] n, s, w0, s0, a, b, diff, num, den, best_num, best_den;
        logic [7:0]  best;
        bit          have;
        lo = 0;
        hi = NUM_BINS - 1;
        n = 0; s = 0; w0 = 0; s0 = 0;
        best = 0; have = 0; best_num = 0; best_den = 0;
        while (lo < NUM_BINS - 1 && hist_bins[lo] == 0) lo++;
        while (hi > lo && hist_bins[hi] == 0) hi--;
        if (hi == lo || hi == lo + 1)
            return lo[7:0];
        for (t = lo; t <= hi; t++)
        begin
            n += hist_bins[t];
            s += 256'(hist_bins[t]) * t;
        end
        for (t = lo; t < hi; t++)
        begin
            w0 += hist_bins[t];
            s0 += 256'(hist_bins[t]) * t;
            a = s0 * n;
            b = s * w0;
            diff = (a >= b) ? a - b : b - a;
            num = diff * diff;
            den = w0 * (n - w0);
            if (!have || num * best_den > best_num * den)
            begin
                have = 1;
                best = t[7:0];
                best_num = num;
                best_den = den;
            end
        end
        return best;
    endfunction

    // Histogram update for one accepted pixel; on last, queues a threshold and clears the histogram.
    function automatic void count_pixel(logic [7:0] pix, logic lst, int want_thr);
        if (hist_bins[pix] < 32'(COUNT_MAX))
            hist_bins[pix]++;
        if (lst)
        begin
            if (want_thr >= 0)
                thr_queue.push_back(want_thr[7:0]);
            else
                thr_queue.push_back(otsu_level());
            foreach (hist_bins[i])
                hist_bins[i] = 0;
            frames_sent++;
        end
    endfunction

    // Offer one request at the falling edge and hold it until accepted.
    task automatic send_pixel(logic [7:0] pix, logic lst, int want_thr);
        while (!calm && $urandom_range(99) < 9)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tlast  <= lst;
        do
            @(posedge clk);
        while (!s_tready);
        count_pixel(pix, lst, want_thr);
        pixels_sent++;
        @(negedge clk);
    endtask

    // Receiver readiness, with random idling and one long hold-off.
    always @(negedge clk)
    begin
        if (hold_req && hold_left == 0)
        begin
            hold_left = 3000;
            hold_req  = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= calm || ($urandom_range(99) >= 9);
    end

    // Compare each accepted threshold with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            thresholds_seen++;
            if (thr_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected threshold %0d", m_tdata);
            end
            else
            begin
                if (m_tdata !== thr_queue[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("threshold mismatch: expected %0d, got %0d",
                                 thr_queue[0], m_tdata);
                end
                void'(thr_queue.pop_front());
            end
        end
    end

    // Run limit.
    initial
    begin
        #400_000_000;
        $display("otsu_frame_threshold_test failed");
        $finish;
    end

    // Stimulus: directed frames, then random frames.
    initial
    begin
        pixel_row_t rows [$];
        int         len;
        int         base;
        int         span;
        int         v;
        bit         held;
        bit         drained;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        mismatches = 0;
        pixels_sent = 0;
        frames_sent = 0;
        thresholds_seen = 0;
        calm = 0;
        hold_req = 0;
        hold_left = 0;
        held = 0;
        drained = 0;
        foreach (hist_bins[i])
            hist_bins[i] = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Single-level frames, adjacent levels, full span, a heavy bin.
        rows = '{
            '{0,     1, 1, 0},
            '{255,   1, 1, 255},
            '{77,    5, 1, 77},
            '{5,     3, 0, -1},
            '{6,     1, 1, 5},
            '{254,   1, 0, -1},
            '{255,   4, 1, 254},
            '{0,     1, 0, -1},
            '{255,   1, 1, -1},
            '{0,     2, 0, -1},
            '{128,   1, 0, -1},
            '{255,   2, 1, -1},
            '{10,    4, 0, -1},
            '{20,    4, 1, -1},
            '{85,    1, 0, -1},
            '{170,   1, 0, -1},
            '{15,    3, 0, -1},
            '{240,   3, 1, -1},
            '{10,   40, 0, -1},
            '{11,    3, 0, -1},
            '{13,    2, 1, -1}
        };
        foreach (rows[r])
            for (int k = 0; k < rows[r].rep; k++)
                send_pixel(rows[r].pixel[7:0],
                           rows[r].last && k == rows[r].rep - 1,
                           (rows[r].last && k == rows[r].rep - 1) ? rows[r].want_thr : -1);

        // Random frames: mostly narrow grey ranges, a few spanning all levels.
        v = 0;
        while (v < 600)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 16);
            if ($urandom_range(99) < 3)
            begin
                base = 0;
                span = 255;
            end
            else
            begin
                base = $urandom_range(255);
                span = $urandom_range(12);
            end
            calm = (v >= 200 && v < 320);
            if (!held && v >= 400)
            begin
                held = 1;
                hold_req = 1;
            end
            for (int k = 0; k < len; k++)
            begin
                int p;
                p = base + $urandom_range(span);
                if (p > 255)
                    p = 255;
                send_pixel(p[7:0], k == len - 1, -1);
                v++;
            end
            // Let the block drain once before continuing.
            if (!drained && v >= 300)
            begin
                drained = 1;
                s_tvalid <= 1'b0;
                while (thr_queue.size() != 0)
                    @(negedge clk);
            end
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        calm = 0;

        while (thr_queue.size() != 0)
            @(negedge clk);
        repeat (600) @(negedge clk);

        $display("covered %0d pixels in %0d frames, %0d thresholds checked",
                 pixels_sent, frames_sent, thresholds_seen);
        if (mismatches == 0)
            $display("otsu_frame_threshold_test passed");
        else
            $display("otsu_frame_threshold_test failed");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/otsu_ft_pkg.sv
hdl/otsu_ft_front.sv
hdl/otsu_ft_mul.sv
hdl/otsu_ft_back.sv
hdl/otsu_frame_threshold.sv
tb/otsu_frame_threshold_test.sv
